// ===== sv/lts_pkg.sv =====
// shared constants, atan table and saturation helper for the lissajous setpoint block
// no dependencies
package lts_pkg;

  localparam int CORDIC_STEPS_DEF = 24;
  localparam int RED_STEPS = 22;
  localparam int RED_STAGES = RED_STEPS / 2;

  localparam logic [32:0] HALF_PI_Q30 = 33'd1686629713;
  localparam logic [32:0] PI_Q30 = 33'd3373259426;
  localparam logic [32:0] PI_3H_Q30 = 33'd5059889139;
  localparam logic [32:0] TWO_PI_Q30 = 33'd6746518852;
  localparam logic signed [33:0] GAIN_INV = 34'sd652032874;

  localparam logic signed [18:0] AMP_AB = 19'sd85197;
  localparam logic signed [18:0] AMP_AB2 = 19'sd170394;
  localparam logic signed [18:0] AMP_C = 19'sd17695;
  localparam logic signed [18:0] AMP_C2 = 19'sd35390;

  localparam logic [54:0] S_CAP = 55'h40000000000000;
  localparam logic [36:0] DS_CAP = 37'h1000000000;

  localparam logic [1:0] BR_RISE = 2'd0;
  localparam logic [1:0] BR_CRUISE = 2'd1;
  localparam logic [1:0] BR_FALL = 2'd2;

  localparam logic [2:0] CFG_ACCEL_TIME = 3'd0;
  localparam logic [2:0] CFG_END_TIME = 3'd1;
  localparam logic [2:0] CFG_CRUISE_RATE = 3'd2;
  localparam logic [2:0] CFG_PEAK_ACCEL = 3'd3;
  localparam logic [2:0] CFG_START_X = 3'd4;
  localparam logic [2:0] CFG_START_Y = 3'd5;
  localparam logic [2:0] CFG_START_Z = 3'd6;

  function automatic logic signed [33:0] atan_q30(input logic [4:0] i);
    logic signed [33:0] a;
    case (i)
      5'd0: a = 34'sh03243F6A8;
      5'd1: a = 34'sh01DAC6705;
      5'd2: a = 34'sh00FADBAFC;
      5'd3: a = 34'sh007F56EA6;
      5'd4: a = 34'sh003FEAB76;
      5'd5: a = 34'sh001FFD55B;
      5'd6: a = 34'sh000FFFAAA;
      5'd7: a = 34'sh0007FFF55;
      5'd8: a = 34'sh0003FFFEA;
      5'd9: a = 34'sh0001FFFFD;
      5'd10: a = 34'sh0000FFFFF;
      5'd11: a = 34'sh00007FFFF;
      5'd12: a = 34'sh00003FFFF;
      5'd13: a = 34'sh00001FFFF;
      5'd14: a = 34'sh00000FFFF;
      5'd15: a = 34'sh000007FFF;
      5'd16: a = 34'sh000003FFF;
      5'd17: a = 34'sh000001FFF;
      5'd18: a = 34'sh000000FFF;
      5'd19: a = 34'sh0000007FF;
      5'd20: a = 34'sh0000003FF;
      5'd21: a = 34'sh0000001FF;
      5'd22: a = 34'sh0000000FF;
      5'd23: a = 34'sh00000007F;
      5'd24: a = 34'sh00000003F;
      5'd25: a = 34'sh00000001F;
      5'd26: a = 34'sh00000000F;
      5'd27: a = 34'sh000000008;
      5'd28: a = 34'sh000000004;
      5'd29: a = 34'sh000000002;
      5'd30: a = 34'sh000000001;
      default: a = 34'sh000000000;
    endcase
    return a;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [71:0] v);
    logic signed [31:0] r;
    if (v > 72'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -72'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// ===== sv/lissajous_trapezoid_setpoint_top.sv =====
// lissajous setpoint generator: trapezoidal path profile, modulo reduction, two cordic lanes
// depends on lts_pkg
//
// channel   direction  handshake           payload
// in        input      in_valid/in_stall   in_sample_time
// out       output     out_valid/out_stall out_pos_x/y/z, out_vel_x/y/z
// cfg       input      cfg_we              cfg_index, cfg_data
//
// one transfer per cycle while the output is not stalled; the pipeline stages are
// 4 profile stages, 11 modulo stages, 1 wrap stage, 1 + CORDIC_STEPS cordic stages and
// 3 output stages including the output register
// synchronous reset clears valid bits and configuration registers
// the whole pipeline holds while a finished result is stalled at the output
module lissajous_trapezoid_setpoint_top import lts_pkg::*; #(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [31:0]        in_sample_time,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_pos_x,
  output logic signed [31:0] out_pos_y,
  output logic signed [31:0] out_pos_z,
  output logic signed [31:0] out_vel_x,
  output logic signed [31:0] out_vel_y,
  output logic signed [31:0] out_vel_z,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  logic [31:0] accel_time_r, end_time_r, cruise_rate_r, peak_accel_r;
  logic signed [31:0] start_x_r, start_y_r, start_z_r;

  logic adv;
  assign adv = !(out_valid && out_stall);
  assign in_stall = !adv;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accel_time_r <= '0;
      end_time_r <= '0;
      cruise_rate_r <= '0;
      peak_accel_r <= '0;
      start_x_r <= '0;
      start_y_r <= '0;
      start_z_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ACCEL_TIME: accel_time_r <= cfg_data;
        CFG_END_TIME: end_time_r <= cfg_data;
        CFG_CRUISE_RATE: cruise_rate_r <= cfg_data;
        CFG_PEAK_ACCEL: peak_accel_r <= cfg_data;
        CFG_START_X: start_x_r <= cfg_data;
        CFG_START_Y: start_y_r <= cfg_data;
        CFG_START_Z: start_z_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage a: branch select
  logic a_v_r, a_hold_r;
  logic [1:0] a_br_r, a_br_nxt;
  logic [31:0] a_u_r, a_u_nxt, a_dt_r, a_dt_nxt;
  logic a_hold_nxt;
  logic [31:0] te;

  always_comb begin
    a_hold_nxt = in_sample_time > end_time_r;
    te = a_hold_nxt ? end_time_r : in_sample_time;
    a_dt_nxt = te - accel_time_r;
    if (te < accel_time_r) begin
      a_br_nxt = BR_RISE;
      a_u_nxt = te;
    end else if (({1'b0, te} + {1'b0, accel_time_r}) <= {1'b0, end_time_r}) begin
      a_br_nxt = BR_CRUISE;
      a_u_nxt = accel_time_r;
    end else begin
      a_br_nxt = BR_FALL;
      a_u_nxt = end_time_r - te;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else if (adv) begin
      a_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_hold_r <= a_hold_nxt;
      a_br_r <= a_br_nxt;
      a_u_r <= a_u_nxt;
      a_dt_r <= a_dt_nxt;
    end
  end

  // stage b: square, rate and linear products
  logic b_v_r, b_hold_r;
  logic [1:0] b_br_r;
  logic [47:0] b_sq_r, b_sq_nxt, b_dsp_r, b_dsp_nxt;
  logic [53:0] b_lin_r, b_lin_nxt;
  logic [63:0] sq_full, dsp_full, lin_full;

  always_comb begin
    sq_full = {32'b0, a_u_r} * {32'b0, a_u_r};
    dsp_full = {32'b0, peak_accel_r} * {32'b0, a_u_r};
    lin_full = {32'b0, cruise_rate_r} * {32'b0, a_dt_r};
    b_sq_nxt = sq_full[63:16];
    b_dsp_nxt = dsp_full[63:16];
    b_lin_nxt = lin_full[63:10];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r <= 1'b0;
    end else if (adv) begin
      b_v_r <= a_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_hold_r <= a_hold_r;
      b_br_r <= a_br_r;
      b_sq_r <= b_sq_nxt;
      b_dsp_r <= b_dsp_nxt;
      b_lin_r <= b_lin_nxt;
    end
  end

  // stage c: partial products of the quadratic term, rate select
  logic c_v_r;
  logic [1:0] c_br_r;
  logic [55:0] c_plo_r, c_plo_nxt, c_phi_r, c_phi_nxt;
  logic [53:0] c_lin_r;
  logic [36:0] c_ds_r, c_ds_nxt;
  logic [47:0] ds_raw;

  always_comb begin
    c_plo_nxt = {32'b0, b_sq_r[23:0]} * {24'b0, peak_accel_r};
    c_phi_nxt = {32'b0, b_sq_r[47:24]} * {24'b0, peak_accel_r};
    ds_raw = (b_br_r == BR_CRUISE) ? {16'b0, cruise_rate_r} : b_dsp_r;
    if (b_hold_r) begin
      c_ds_nxt = '0;
    end else if (ds_raw > {11'b0, DS_CAP}) begin
      c_ds_nxt = DS_CAP;
    end else begin
      c_ds_nxt = ds_raw[36:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_v_r <= 1'b0;
    end else if (adv) begin
      c_v_r <= b_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_br_r <= b_br_r;
      c_plo_r <= c_plo_nxt;
      c_phi_r <= c_phi_nxt;
      c_lin_r <= b_lin_r;
      c_ds_r <= c_ds_nxt;
    end
  end

  // stage d and modulo 2pi reduction chain
  logic red_v_r [0:RED_STAGES];
  logic red_neg_r [0:RED_STAGES];
  logic [54:0] red_w_r [0:RED_STAGES];
  logic [54:0] red_w_nxt [0:RED_STAGES];
  logic [36:0] red_ds_r [0:RED_STAGES];
  logic [79:0] prod;
  logic [54:0] q;
  logic [55:0] csum;

  always_comb begin
    prod = {c_phi_r, 24'b0} + {24'b0, c_plo_r};
    q = (prod[79:64] != 16'b0) ? S_CAP : {2'b0, prod[63:11]};
    csum = {1'b0, q} + {2'b0, c_lin_r};
    if (c_br_r == BR_CRUISE) begin
      red_w_nxt[0] = (csum > {1'b0, S_CAP}) ? S_CAP : csum[54:0];
    end else begin
      red_w_nxt[0] = q;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      red_v_r[0] <= 1'b0;
    end else if (adv) begin
      red_v_r[0] <= c_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      red_w_r[0] <= red_w_nxt[0];
      red_neg_r[0] <= (c_br_r == BR_FALL);
      red_ds_r[0] <= c_ds_r;
    end
  end

  for (genvar j = 0; j < RED_STAGES; j++) begin : g_red
    localparam int K0 = RED_STEPS - 1 - 2 * j;
    logic [54:0] w_mid;
    logic [54:0] m0, m1;

    always_comb begin
      m0 = {22'b0, TWO_PI_Q30} << K0;
      m1 = {22'b0, TWO_PI_Q30} << (K0 - 1);
      w_mid = (red_w_r[j] >= m0) ? (red_w_r[j] - m0) : red_w_r[j];
      red_w_nxt[j+1] = (w_mid >= m1) ? (w_mid - m1) : w_mid;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        red_v_r[j+1] <= 1'b0;
      end else if (adv) begin
        red_v_r[j+1] <= red_v_r[j];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        red_w_r[j+1] <= red_w_nxt[j+1];
        red_neg_r[j+1] <= red_neg_r[j];
        red_ds_r[j+1] <= red_ds_r[j];
      end
    end
  end

  // stage f: path angle and double angle
  logic f_v_r;
  logic [32:0] f_r1_r, f_r1_nxt, f_r2_r, f_r2_nxt;
  logic [36:0] f_ds_r;
  logic [32:0] rq;
  logic [33:0] dbl;

  always_comb begin
    rq = red_w_r[RED_STAGES][32:0];
    if (red_neg_r[RED_STAGES] && (rq != 33'b0)) begin
      f_r1_nxt = TWO_PI_Q30 - rq;
    end else begin
      f_r1_nxt = rq;
    end
    dbl = {f_r1_nxt, 1'b0};
    f_r2_nxt = (dbl >= {1'b0, TWO_PI_Q30}) ? (dbl[32:0] - TWO_PI_Q30) : dbl[32:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_v_r <= 1'b0;
    end else if (adv) begin
      f_v_r <= red_v_r[RED_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f_r1_r <= f_r1_nxt;
      f_r2_r <= f_r2_nxt;
      f_ds_r <= red_ds_r[RED_STAGES];
    end
  end

  // cordic lanes: lane 1 on s, lane 2 on 2s
  logic cv_r [0:CORDIC_STEPS];
  logic cf1_r [0:CORDIC_STEPS];
  logic cf2_r [0:CORDIC_STEPS];
  logic [36:0] cds_r [0:CORDIC_STEPS];
  logic signed [33:0] c1x_r [0:CORDIC_STEPS];
  logic signed [33:0] c1y_r [0:CORDIC_STEPS];
  logic signed [33:0] c1z_r [0:CORDIC_STEPS];
  logic signed [33:0] c2x_r [0:CORDIC_STEPS];
  logic signed [33:0] c2y_r [0:CORDIC_STEPS];
  logic signed [33:0] c2z_r [0:CORDIC_STEPS];
  logic signed [33:0] z1_nxt, z2_nxt;
  logic f1_nxt, f2_nxt;

  function automatic logic signed [33:0] fold_z(input logic [32:0] r);
    logic signed [34:0] rs;
    logic signed [34:0] zz;
    rs = $signed({2'b0, r});
    if ((r > HALF_PI_Q30) && (r < PI_3H_Q30)) begin
      zz = rs - $signed({2'b0, PI_Q30});
    end else if (r >= PI_3H_Q30) begin
      zz = rs - $signed({2'b0, TWO_PI_Q30});
    end else begin
      zz = rs;
    end
    return zz[33:0];
  endfunction

  always_comb begin
    z1_nxt = fold_z(f_r1_r);
    z2_nxt = fold_z(f_r2_r);
    f1_nxt = (f_r1_r > HALF_PI_Q30) && (f_r1_r < PI_3H_Q30);
    f2_nxt = (f_r2_r > HALF_PI_Q30) && (f_r2_r < PI_3H_Q30);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cv_r[0] <= 1'b0;
    end else if (adv) begin
      cv_r[0] <= f_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cf1_r[0] <= f1_nxt;
      cf2_r[0] <= f2_nxt;
      cds_r[0] <= f_ds_r;
      c1x_r[0] <= GAIN_INV;
      c1y_r[0] <= '0;
      c1z_r[0] <= z1_nxt;
      c2x_r[0] <= GAIN_INV;
      c2y_r[0] <= '0;
      c2z_r[0] <= z2_nxt;
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    logic signed [33:0] at;
    logic signed [33:0] x1_nxt, y1_nxt, zz1_nxt, x2_nxt, y2_nxt, zz2_nxt;

    always_comb begin
      at = atan_q30(5'(i));
      if (!c1z_r[i][33]) begin
        x1_nxt = c1x_r[i] - (c1y_r[i] >>> i);
        y1_nxt = c1y_r[i] + (c1x_r[i] >>> i);
        zz1_nxt = c1z_r[i] - at;
      end else begin
        x1_nxt = c1x_r[i] + (c1y_r[i] >>> i);
        y1_nxt = c1y_r[i] - (c1x_r[i] >>> i);
        zz1_nxt = c1z_r[i] + at;
      end
      if (!c2z_r[i][33]) begin
        x2_nxt = c2x_r[i] - (c2y_r[i] >>> i);
        y2_nxt = c2y_r[i] + (c2x_r[i] >>> i);
        zz2_nxt = c2z_r[i] - at;
      end else begin
        x2_nxt = c2x_r[i] + (c2y_r[i] >>> i);
        y2_nxt = c2y_r[i] - (c2x_r[i] >>> i);
        zz2_nxt = c2z_r[i] + at;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        cv_r[i+1] <= 1'b0;
      end else if (adv) begin
        cv_r[i+1] <= cv_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        cf1_r[i+1] <= cf1_r[i];
        cf2_r[i+1] <= cf2_r[i];
        cds_r[i+1] <= cds_r[i];
        c1x_r[i+1] <= x1_nxt;
        c1y_r[i+1] <= y1_nxt;
        c1z_r[i+1] <= zz1_nxt;
        c2x_r[i+1] <= x2_nxt;
        c2y_r[i+1] <= y2_nxt;
        c2z_r[i+1] <= zz2_nxt;
      end
    end
  end

  // stage g: amplitude products
  logic g_v_r;
  logic [36:0] g_ds_r;
  logic signed [31:0] g_px_r, g_py_r, g_pz_r, g_m1_r, g_m2_r, g_m3_r;
  logic signed [31:0] g_px_nxt, g_py_nxt, g_pz_nxt, g_m1_nxt, g_m2_nxt, g_m3_nxt;
  logic signed [33:0] c1, s1, c2, s2;
  logic signed [52:0] p_px, p_py, p_pz, p_m1, p_m2, p_m3;
  logic signed [52:0] t_px, t_py, t_pz, t_m1, t_m2, t_m3;

  localparam logic signed [52:0] HALF30 = 53'sd536870912;
  localparam logic signed [52:0] HALF22 = 53'sd2097152;

  always_comb begin
    c1 = cf1_r[CORDIC_STEPS] ? -c1x_r[CORDIC_STEPS] : c1x_r[CORDIC_STEPS];
    s1 = cf1_r[CORDIC_STEPS] ? -c1y_r[CORDIC_STEPS] : c1y_r[CORDIC_STEPS];
    c2 = cf2_r[CORDIC_STEPS] ? -c2x_r[CORDIC_STEPS] : c2x_r[CORDIC_STEPS];
    s2 = cf2_r[CORDIC_STEPS] ? -c2y_r[CORDIC_STEPS] : c2y_r[CORDIC_STEPS];
    p_px = AMP_AB * s1;
    p_py = AMP_AB * s2;
    p_pz = AMP_C * c2;
    p_m1 = AMP_AB * c1;
    p_m2 = AMP_AB2 * c2;
    p_m3 = AMP_C2 * s2;
    t_px = (p_px + HALF30) >>> 30;
    t_py = (p_py + HALF30) >>> 30;
    t_pz = (p_pz + HALF30) >>> 30;
    t_m1 = (p_m1 + HALF22) >>> 22;
    t_m2 = (p_m2 + HALF22) >>> 22;
    t_m3 = (p_m3 + HALF22) >>> 22;
    g_px_nxt = t_px[31:0];
    g_py_nxt = t_py[31:0];
    g_pz_nxt = t_pz[31:0];
    g_m1_nxt = t_m1[31:0];
    g_m2_nxt = t_m2[31:0];
    g_m3_nxt = t_m3[31:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g_v_r <= 1'b0;
    end else if (adv) begin
      g_v_r <= cv_r[CORDIC_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      g_ds_r <= cds_r[CORDIC_STEPS];
      g_px_r <= g_px_nxt;
      g_py_r <= g_py_nxt;
      g_pz_r <= g_pz_nxt;
      g_m1_r <= g_m1_nxt;
      g_m2_r <= g_m2_nxt;
      g_m3_r <= g_m3_nxt;
    end
  end

  // stage h: rate partial products, positions
  logic h_v_r;
  logic signed [50:0] h_lo1_r, h_lo2_r, h_lo3_r;
  logic signed [51:0] h_hi1_r, h_hi2_r, h_hi3_r;
  logic signed [31:0] h_px_r, h_py_r, h_pz_r;
  logic signed [31:0] h_px_nxt, h_py_nxt, h_pz_nxt;
  logic signed [18:0] ds_lo;
  logic signed [19:0] ds_hi;

  always_comb begin
    ds_lo = $signed({1'b0, g_ds_r[17:0]});
    ds_hi = $signed({1'b0, g_ds_r[36:18]});
    h_px_nxt = sat32(72'(start_x_r) - 72'(g_px_r));
    h_py_nxt = sat32(72'(start_y_r) + 72'(g_py_r));
    h_pz_nxt = sat32(72'(start_z_r) + 72'(g_pz_r) - 72'(AMP_C));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h_v_r <= 1'b0;
    end else if (adv) begin
      h_v_r <= g_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      h_lo1_r <= g_m1_r * ds_lo;
      h_lo2_r <= g_m2_r * ds_lo;
      h_lo3_r <= g_m3_r * ds_lo;
      h_hi1_r <= g_m1_r * ds_hi;
      h_hi2_r <= g_m2_r * ds_hi;
      h_hi3_r <= g_m3_r * ds_hi;
      h_px_r <= h_px_nxt;
      h_py_r <= h_py_nxt;
      h_pz_r <= h_pz_nxt;
    end
  end

  // output register: velocity sums and rounding
  logic out_valid_r;
  logic signed [31:0] pos_x_r, pos_y_r, pos_z_r, vel_x_r, vel_y_r, vel_z_r;
  logic signed [31:0] vel_x_nxt, vel_y_nxt, vel_z_nxt;

  localparam logic signed [71:0] HALF32 = 72'sd2147483648;

  function automatic logic signed [71:0] vel_round(input logic signed [51:0] hi,
                                                    input logic signed [50:0] lo);
    logic signed [71:0] sum;
    sum = (72'(hi) <<< 18) + 72'(lo);
    return (sum + HALF32) >>> 32;
  endfunction

  always_comb begin
    vel_x_nxt = sat32(-vel_round(h_hi1_r, h_lo1_r));
    vel_y_nxt = sat32(vel_round(h_hi2_r, h_lo2_r));
    vel_z_nxt = sat32(-vel_round(h_hi3_r, h_lo3_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= h_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pos_x_r <= h_px_r;
      pos_y_r <= h_py_r;
      pos_z_r <= h_pz_r;
      vel_x_r <= vel_x_nxt;
      vel_y_r <= vel_y_nxt;
      vel_z_r <= vel_z_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_pos_x = pos_x_r;
  assign out_pos_y = pos_y_r;
  assign out_pos_z = pos_z_r;
  assign out_vel_x = vel_x_r;
  assign out_vel_y = vel_y_r;
  assign out_vel_z = vel_z_r;

endmodule

// ===== tb/sv/tb_top.sv =====
// testbench for the lissajous trapezoid setpoint generator: directed table then random samples
// depends on lts_pkg and lissajous_trapezoid_setpoint_top; predictor is built in
module tb_top import lts_pkg::*; ();

  localparam int STEPS = 24;
  localparam int LAT = 20 + STEPS;
  localparam longint TWO_PI = 64'sd6746518852;
  localparam longint HALF_PI = 64'sd1686629713;
  localparam longint PI_V = 64'sd3373259426;
  localparam longint SCAP = 64'sd1 <<< 54;
  localparam longint DSCAP = 64'sd1 <<< 36;
  localparam longint K_AB = 85197;
  localparam longint K_C = 17695;
  localparam longint LIMIT = 400000;

  typedef struct packed {
    logic signed [31:0] px, py, pz, vx, vy, vz;
  } setpoint_t;

  logic clk = 1'b0, rst_n = 1'b0;
  logic in_valid = 1'b0, in_stall;
  logic [31:0] in_sample_time = '0;
  logic out_valid, out_stall = 1'b0;
  logic signed [31:0] out_pos_x, out_pos_y, out_pos_z, out_vel_x, out_vel_y, out_vel_z;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  logic [31:0] r_tb, r_tf, r_cr, r_pk;
  logic signed [31:0] r_sx, r_sy, r_sz;

  setpoint_t setpoint_q[$];
  int mismatches = 0;
  longint cycles = 0;
  bit hold_off = 0;
  bit stim_done = 0;

  lissajous_trapezoid_setpoint_top uut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("lissajous_trapezoid_setpoint_top verification failed");
      $finish;
    end
  end

  function automatic longint shr(longint v, int n);
    return v >>> n;
  endfunction

  function automatic longint rnd(longint v, int n);
    return (v + (64'sd1 <<< (n - 1))) >>> n;
  endfunction

  function automatic longint sat(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint quad(longint unsigned u);
    longint unsigned v, p;
    v = (u * u) >> 16;
    if (v != 0 && longint'(r_pk) != 0 && (64'hFFFF_FFFF_FFFF_FFFF / v) < r_pk) return SCAP;
    p = (v * r_pk) >> 11;
    return (p > SCAP) ? SCAP : longint'(p);
  endfunction

  function automatic longint wrap(longint a);
    longint r;
    r = a % TWO_PI;
    if (r < 0) r += TWO_PI;
    return r;
  endfunction

  function automatic void rotate(input longint r, output longint cs, output longint sn);
    longint z, x, y, nx;
    bit flip;
    z = r; x = 652032874; y = 0; flip = 0;
    if (r > HALF_PI && r < PI_V + HALF_PI) begin
      z = r - PI_V; flip = 1;
    end else if (r >= PI_V + HALF_PI) begin
      z = r - TWO_PI;
    end
    for (int i = 0; i < STEPS; i++) begin
      if (z >= 0) begin
        nx = x - shr(y, i); y = y + shr(x, i); z -= longint'(atan_q30(i[4:0]));
      end else begin
        nx = x + shr(y, i); y = y - shr(x, i); z += longint'(atan_q30(i[4:0]));
      end
      x = nx;
    end
    cs = flip ? -x : x;
    sn = flip ? -y : y;
  endfunction

  function automatic longint vel(longint amp, longint trig, longint ds);
    return rnd(rnd(amp * trig, 22) * ds, 32);
  endfunction

  function automatic setpoint_t predict_setpoint(logic [31:0] t);
    setpoint_t e;
    bit hold;
    longint unsigned te, u;
    longint ti, tb, tf, s, ds, r1, r2, c1, s1, c2, s2;
    hold = t > r_tf;
    te = 64'(hold ? r_tf : t);
    ti = te; tb = longint'(r_tb); tf = longint'(r_tf);
    if (ti < tb) begin
      s = quad(te);
      ds = longint'((longint'(r_pk) * te) >> 16);
    end else if (ti <= tf - tb) begin
      s = quad(64'(r_tb)) + longint'((longint'(r_cr) * (te - r_tb)) >> 10);
      if (s > SCAP) s = SCAP;
      ds = longint'(r_cr);
    end else begin
      u = tf - ti;
      s = TWO_PI - quad(u);
      ds = longint'((longint'(r_pk) * u) >> 16);
    end
    if (ds > DSCAP) ds = DSCAP;
    if (hold) ds = 0;
    r1 = wrap(s);
    r2 = wrap(2 * r1);
    rotate(r1, c1, s1);
    rotate(r2, c2, s2);
    e.px = 32'(sat(r_sx - rnd(K_AB * s1, 30)));
    e.py = 32'(sat(r_sy + rnd(K_AB * s2, 30)));
    e.pz = 32'(sat(r_sz + rnd(K_C * c2, 30) - K_C));
    e.vx = 32'(sat(-vel(K_AB, c1, ds)));
    e.vy = 32'(sat(vel(2 * K_AB, c2, ds)));
    e.vz = 32'(sat(-vel(2 * K_C, s2, ds)));
    return e;
  endfunction

  // write enable stays high across back to back writes; load_profile drops it
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    case (idx)
      CFG_ACCEL_TIME: r_tb = val;
      CFG_END_TIME: r_tf = val;
      CFG_CRUISE_RATE: r_cr = val;
      CFG_PEAK_ACCEL: r_pk = val;
      CFG_START_X: r_sx = val;
      CFG_START_Y: r_sy = val;
      default: r_sz = val;
    endcase
  endtask

  task automatic load_profile(input logic [31:0] tb, tf, cr, pk, sx, sy, sz);
    while (setpoint_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    write_reg(CFG_ACCEL_TIME, tb); write_reg(CFG_END_TIME, tf);
    write_reg(CFG_CRUISE_RATE, cr); write_reg(CFG_PEAK_ACCEL, pk);
    write_reg(CFG_START_X, sx); write_reg(CFG_START_Y, sy); write_reg(CFG_START_Z, sz);
    cfg_we <= 1'b0;
  endtask

  // expected setpoint is queued at the edge the transfer happens
  task automatic send_sample(input logic [31:0] t, input bit typed, input setpoint_t want);
    if ($urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(0, 9) == 0 ? $urandom_range(10, 40) : $urandom_range(1, 3))
        @(posedge clk);
    end
    in_valid <= 1'b1;
    in_sample_time <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    setpoint_q.push_back(typed ? want : predict_setpoint(t));
  endtask

  task automatic compare(input setpoint_t e, input setpoint_t a);
    if (e !== a) begin
      mismatches++;
      if (mismatches <= 10)
        $display("setpoint mismatch exp %h %h %h %h %h %h got %h %h %h %h %h %h",
                 e.px, e.py, e.pz, e.vx, e.vy, e.vz, a.px, a.py, a.pz, a.vx, a.vy, a.vz);
    end
  endtask

  always @(posedge clk) begin
    setpoint_t got;
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_pos_x, out_pos_y, out_pos_z, out_vel_x, out_vel_y, out_vel_z};
      if (setpoint_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("setpoint transfer with nothing expected");
      end else begin
        compare(setpoint_q.pop_front(), got);
      end
    end
  end

  // receiver stalls; one long hold-off while the sender keeps going
  initial begin
    int n;
    @(posedge rst_n);
    forever begin
      if (hold_off) begin
        out_stall <= 1'b1;
        repeat (120) @(posedge clk);
        hold_off = 0;
      end
      n = $urandom_range(0, 9);
      if (n < 6) begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else begin
        out_stall <= 1'b1;
        repeat (n == 9 ? $urandom_range(10, 50) : $urandom_range(1, 3)) @(posedge clk);
      end
    end
  end

  typedef struct {
    logic [31:0] t;
    bit typed;
    setpoint_t want;
  } row_t;

  initial begin
    row_t rows[$];
    setpoint_t zero_pt;
    logic [31:0] nom_t [0:10];
    r_tb = 0; r_tf = 0; r_cr = 0; r_pk = 0; r_sx = 0; r_sy = 0; r_sz = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // all-zero registers: s = 0 always, past end for any t > 0
    zero_pt = '{32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0};
    rows.push_back('{32'd0, 1'b1, zero_pt});
    rows.push_back('{32'hFFFF_FFFF, 1'b1, zero_pt});
    rows.push_back('{32'h0000_0001, 1'b1, zero_pt});
    foreach (rows[i]) send_sample(rows[i].t, rows[i].typed, rows[i].want);
    in_valid <= 1'b0;
    rows.delete();

    // nominal profile: 2 s blend, 10 s end, rate 2pi/8, accel rate/2
    load_profile(32'h0002_0000, 32'h000A_0000, 32'h00C9_0FDB, 32'h0064_87ED,
                 32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000);
    nom_t = '{32'h0, 32'h8000, 32'h1_FFFF, 32'h2_0000, 32'h5_0000, 32'h8_0000,
              32'h8_0001, 32'h9_FFFF, 32'hA_0000, 32'hA_0001, 32'hFFFF_FFFF};
    foreach (nom_t[i]) send_sample(nom_t[i], 1'b0, zero_pt);
    in_valid <= 1'b0;

    // extremes: saturating terms and starts, inconsistent timing
    load_profile(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
    for (int i = 0; i < 5; i++)
      send_sample(i == 0 ? 32'h0 : (i == 4 ? 32'hFFFF_FFFF : $urandom), 1'b0, zero_pt);
    in_valid <= 1'b0;
    load_profile(32'h0008_0000, 32'h000A_0000, 32'h0100_0000, 32'h0200_0000,
                 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    for (int i = 0; i < 6; i++) send_sample(i * 32'h2_0000, 1'b0, zero_pt);
    in_valid <= 1'b0;

    // random phases, samples mostly inside the trajectory
    for (int ph = 0; ph < 6; ph++) begin
      logic [31:0] tf;
      tf = (ph == 5) ? $urandom : $urandom_range(32'h1_0000, 32'h40_0000);
      load_profile($urandom_range(0, tf), tf, $urandom, $urandom >> $urandom_range(0, 16),
                   $urandom, $urandom, $urandom);
      for (int i = 0; i < 100; i++) begin
        if (ph == 2 && i == 30) hold_off = 1;
        send_sample($urandom_range(0, 7) == 0 ? $urandom : $urandom_range(0, tf + 32'h100),
                    1'b0, zero_pt);
      end
      in_valid <= 1'b0;
    end

    while (setpoint_q.size() != 0) @(posedge clk);
    repeat (LAT) @(posedge clk);
    if (mismatches == 0 && setpoint_q.size() == 0)
      $display("lissajous_trapezoid_setpoint_top verification clean");
    else
      $display("lissajous_trapezoid_setpoint_top verification failed");
    $finish;
  end
endmodule
